// ===== sv/plel_pkg.sv =====
package plel_pkg;

  // Store geometry and field widths.
  localparam int CAPACITY  = 64;
  localparam int DATA_W    = 32;
  localparam int POS_W     = 7;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;

  // Result gathering: cells are reduced in groups, one register level per group.
  localparam int GRP_SIZE  = 8;
  localparam int NUM_GRP   = CAPACITY / GRP_SIZE;
  localparam int GRP_IDX_W = $clog2(GRP_SIZE);
  localparam int GRP_SEL_W = $clog2(NUM_GRP);

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_FIND   = 2'd2,
    REQ_GET    = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BADPOS  = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic              ins_en;
    logic              del_en;
    logic [POS_W-1:0]  pos;
    logic [CNT_W-1:0]  count;
    logic [DATA_W-1:0] value;
  } plel_cmd_t;

  // Registered summary of one group of cells.
  typedef struct packed {
    logic                 any;
    logic [GRP_IDX_W-1:0] low;
    logic [DATA_W-1:0]    rd;
  } plel_grp_t;

endpackage

// ===== sv/plel_cell.sv =====
module plel_cell (
  input  logic                         clk_i,
  input  plel_pkg::plel_cmd_t          cmd_i,
  input  logic [plel_pkg::IDX_W-1:0]   idx_i,
  input  logic [plel_pkg::DATA_W-1:0]  left_i,
  input  logic [plel_pkg::DATA_W-1:0]  right_i,
  output logic [plel_pkg::DATA_W-1:0]  data_o,
  output logic [plel_pkg::DATA_W-1:0]  sel_data_o,
  output logic                         hit_o
);
  import plel_pkg::*;

  logic [DATA_W-1:0] data_q, data_d;
  logic [POS_W-1:0]  idx_ext;

  assign idx_ext = POS_W'(idx_i);

  // Insert moves entries above the position up; delete pulls them down.
  always_comb begin
    data_d = data_q;
    if (cmd_i.ins_en) begin
      if (idx_ext > cmd_i.pos) begin
        data_d = left_i;
      end else if (idx_ext == cmd_i.pos) begin
        data_d = cmd_i.value;
      end
    end else if (cmd_i.del_en && (idx_ext >= cmd_i.pos)) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // Local read select and key compare against the current contents.
  assign data_o     = data_q;
  assign sel_data_o = (idx_ext == cmd_i.pos) ? data_q : '0;
  assign hit_o      = (idx_ext < cmd_i.count) && (data_q == cmd_i.value);

endmodule

// ===== sv/plel_gather.sv =====
module plel_gather (
  input  logic                                             clk_i,
  input  logic                                             capture_i,
  input  logic [plel_pkg::GRP_SIZE-1:0][plel_pkg::DATA_W-1:0] sel_data_i,
  input  logic [plel_pkg::GRP_SIZE-1:0]                    hit_i,
  output plel_pkg::plel_grp_t                              sum_o
);
  import plel_pkg::*;

  plel_grp_t sum_q, sum_d;

  // Lowest hitting cell of the group and the OR of the selected data.
  always_comb begin
    sum_d = '0;
    for (int k = GRP_SIZE - 1; k >= 0; k--) begin
      if (hit_i[k]) begin
        sum_d.any = 1'b1;
        sum_d.low = GRP_IDX_W'(k);
      end
      sum_d.rd = sum_d.rd | sel_data_i[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

// ===== sv/positional_list_engine_core.sv =====
// Channel   Direction  Handshake                   Payload
// request   in         in_valid_i / in_ready_o     req_type_i, position_i, value_i
// response  out        out_valid_o / out_ready_i   status_o, read_value_o,
//                                                  found_index_o, list_count_o
//
// One request is handled at a time. A beat is accepted when the block is idle;
// the cell chain shifts and compares in that cycle, the group summaries are
// registered, and the response is registered in the cycle after. No new request
// is taken until the response has been taken. Reset clears the entry count and
// the control state; the cell contents are not reset. A stalled response holds
// until out_ready_i is seen high.
module positional_list_engine_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    req_type_i,
  input  logic [plel_pkg::POS_W-1:0]    position_i,
  input  logic signed [plel_pkg::DATA_W-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic signed [plel_pkg::DATA_W-1:0] read_value_o,
  output logic [plel_pkg::IDX_W-1:0]    found_index_o,
  output logic [plel_pkg::CNT_W-1:0]    list_count_o
);
  import plel_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GATHER,
    S_RESULT
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  count_q, count_d;
  req_e              req_q;
  status_e           pre_status_q;
  logic              rd_en_q;
  logic              out_valid_q;
  status_e           status_q;
  logic [DATA_W-1:0] read_value_q;
  logic [IDX_W-1:0]  found_index_q;
  logic [CNT_W-1:0]  list_count_q;

  logic              fire;
  logic              ins_pos_ok, rd_pos_ok, full;
  status_e           pre_status_d;
  logic              rd_en_d;
  plel_cmd_t         cmd;

  logic [CAPACITY-1:0][DATA_W-1:0] cell_data;
  logic [CAPACITY-1:0][DATA_W-1:0] sel_data;
  logic [CAPACITY-1:0]             hit;
  plel_grp_t                       grp_sum [NUM_GRP];

  logic                 any_hit;
  logic [GRP_SEL_W-1:0] hit_grp;
  logic [IDX_W-1:0]     hit_idx;
  logic [DATA_W-1:0]    rd_all;

  assign in_ready_o = (state_q == S_IDLE);
  assign fire       = in_valid_i && in_ready_o;

  // Request checks against the current count.
  assign ins_pos_ok = (position_i <= count_q);
  assign rd_pos_ok  = (position_i < count_q);
  assign full       = (count_q == CNT_W'(CAPACITY));

  always_comb begin
    cmd          = '0;
    cmd.pos      = position_i;
    cmd.count    = count_q;
    cmd.value    = value_i;
    count_d      = count_q;
    pre_status_d = ST_OK;
    rd_en_d      = 1'b0;
    case (req_e'(req_type_i))
      REQ_INSERT: begin
        if (!ins_pos_ok) begin
          pre_status_d = ST_BADPOS;
        end else if (full) begin
          pre_status_d = ST_FULL;
        end else begin
          cmd.ins_en = fire;
          count_d    = count_q + CNT_W'(1);
        end
      end
      REQ_DELETE: begin
        if (!rd_pos_ok) begin
          pre_status_d = ST_BADPOS;
        end else begin
          cmd.del_en = fire;
          rd_en_d    = 1'b1;
          count_d    = count_q - CNT_W'(1);
        end
      end
      REQ_GET: begin
        if (!rd_pos_ok) begin
          pre_status_d = ST_BADPOS;
        end else begin
          rd_en_d = 1'b1;
        end
      end
      default: begin
        pre_status_d = ST_OK;
      end
    endcase
  end

  // Chain of cells; each hands its entry to both neighbors.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [DATA_W-1:0] left_w, right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[k+1];
    end
    plel_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .idx_i      (IDX_W'(k)),
      .left_i     (left_w),
      .right_i    (right_w),
      .data_o     (cell_data[k]),
      .sel_data_o (sel_data[k]),
      .hit_o      (hit[k])
    );
  end

  // First reduction level, captured as the request is accepted.
  for (genvar g = 0; g < NUM_GRP; g++) begin : g_grp
    plel_gather u_gather (
      .clk_i      (clk_i),
      .capture_i  (fire),
      .sel_data_i (sel_data[g*GRP_SIZE +: GRP_SIZE]),
      .hit_i      (hit[g*GRP_SIZE +: GRP_SIZE]),
      .sum_o      (grp_sum[g])
    );
  end

  // Second reduction level over the group summaries.
  always_comb begin
    any_hit = 1'b0;
    hit_grp = '0;
    rd_all  = '0;
    for (int g = NUM_GRP - 1; g >= 0; g--) begin
      if (grp_sum[g].any) begin
        any_hit = 1'b1;
        hit_grp = GRP_SEL_W'(g);
      end
      rd_all = rd_all | grp_sum[g].rd;
    end
    hit_idx = {hit_grp, grp_sum[hit_grp].low};
  end

  // Sequencer, entry count and response registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      count_q       <= '0;
      req_q         <= REQ_INSERT;
      pre_status_q  <= ST_OK;
      rd_en_q       <= 1'b0;
      out_valid_q   <= 1'b0;
      status_q      <= ST_OK;
      read_value_q  <= '0;
      found_index_q <= '0;
      list_count_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (fire) begin
            req_q        <= req_e'(req_type_i);
            pre_status_q <= pre_status_d;
            rd_en_q      <= rd_en_d;
            count_q      <= count_d;
            state_q      <= S_GATHER;
          end
        end
        S_GATHER: begin
          status_q      <= pre_status_q;
          found_index_q <= '0;
          if (req_q == REQ_FIND) begin
            if (any_hit) begin
              found_index_q <= hit_idx;
            end else begin
              status_q <= ST_MISSING;
            end
          end
          read_value_q <= rd_en_q ? rd_all : '0;
          list_count_q <= count_q;
          out_valid_q  <= 1'b1;
          state_q      <= S_RESULT;
        end
        S_RESULT: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign read_value_o  = read_value_q;
  assign found_index_o = found_index_q;
  assign list_count_o  = list_count_q;

endmodule

// ===== dv/positional_list_engine_core_test.sv =====
`timescale 1ns / 1ps

module positional_list_engine_core_test;

  import plel_pkg::*;

  // One queued request, plus a flag that holds it back until the block has drained.
  typedef struct {
    req_e               op;
    logic [POS_W-1:0]   pos;
    logic [DATA_W-1:0]  val;
    bit                 drain;
  } list_req_t;

  // One expected response.
  typedef struct packed {
    status_e            status;
    logic [DATA_W-1:0]  rd;
    logic [IDX_W-1:0]   idx;
    logic [CNT_W-1:0]   cnt;
  } list_rsp_t;

  localparam int RANDOM_ITEMS = 1528;

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     in_valid_i   = 1'b0;
  logic                     in_ready_o;
  logic [1:0]               req_type_i   = '0;
  logic [POS_W-1:0]         position_i   = '0;
  logic signed [DATA_W-1:0] value_i      = '0;
  logic                     out_valid_o;
  logic                     out_ready_i  = 1'b0;
  logic [1:0]               status_o;
  logic signed [DATA_W-1:0] read_value_o;
  logic [IDX_W-1:0]         found_index_o;
  logic [CNT_W-1:0]         list_count_o;

  // Mirror of the list contents as the block should hold them.
  logic [DATA_W-1:0] mirror_mem [CAPACITY];
  int                mirror_len = 0;

  list_req_t   pending_reqs [$];
  list_rsp_t   expected_rsps [$];
  logic [DATA_W-1:0] key_pool [16];

  int gen_len = 0;
  int sent_count = 0;
  int mismatches = 0;
  int tx_pause = 0;
  int tx_calm = 0;
  int rx_hold = 0;
  int rx_calm = 0;
  bit tx_show;
  list_req_t nxt_req;
  list_rsp_t want;

  positional_list_engine_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .read_value_o  (read_value_o),
    .found_index_o (found_index_o),
    .list_count_o  (list_count_o)
  );

  always #5 clk_i = ~clk_i;

  // Applies one request to the mirror list and returns the response it should give.
  function automatic list_rsp_t list_apply(req_e op, logic [POS_W-1:0] pos,
                                           logic [DATA_W-1:0] val);
    list_rsp_t r;
    bit        hit;
    r   = '{status: ST_OK, rd: '0, idx: '0, cnt: '0};
    hit = 1'b0;
    case (op)
      REQ_INSERT: begin
        if (int'(pos) > mirror_len) begin
          r.status = ST_BADPOS;
        end else if (mirror_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (int k = mirror_len; k > int'(pos); k--) mirror_mem[k] = mirror_mem[k-1];
          mirror_mem[pos] = val;
          mirror_len++;
        end
      end
      REQ_DELETE: begin
        if (int'(pos) >= mirror_len) begin
          r.status = ST_BADPOS;
        end else begin
          r.rd = mirror_mem[pos];
          for (int k = int'(pos); k + 1 < mirror_len; k++) mirror_mem[k] = mirror_mem[k+1];
          mirror_len--;
        end
      end
      REQ_FIND: begin
        for (int k = 0; k < mirror_len; k++) begin
          if (!hit && mirror_mem[k] == val) begin
            hit   = 1'b1;
            r.idx = k[IDX_W-1:0];
          end
        end
        if (!hit) r.status = ST_MISSING;
      end
      default: begin
        if (int'(pos) >= mirror_len) r.status = ST_BADPOS;
        else r.rd = mirror_mem[pos];
      end
    endcase
    r.cnt = mirror_len[CNT_W-1:0];
    return r;
  endfunction

  // Queues a request and tracks the list length it leaves behind.
  function automatic void add_req(req_e op, int pos, logic [DATA_W-1:0] val, bit drain);
    pending_reqs.push_back('{op: op, pos: pos[POS_W-1:0], val: val, drain: drain});
    if (op == REQ_INSERT && pos <= gen_len && gen_len < CAPACITY) gen_len++;
    else if (op == REQ_DELETE && pos < gen_len) gen_len--;
  endfunction

  // Draws a value, from the small pool of repeated keys with the given chance.
  function automatic logic [DATA_W-1:0] pick_value(int pool_pct);
    if ($urandom_range(0, 99) < pool_pct) return key_pool[$urandom_range(0, 15)];
    return $urandom;
  endfunction

  // Pause length: mostly none, some short, a few long, with calm stretches of none.
  function automatic int next_pause(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void check_field(string name, logic [DATA_W-1:0] exp_v,
                                      logic [DATA_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // Request driver: presents queued beats, with gaps between them. A beat accepted at
  // this edge still counts as outstanding for a request that waits for the drain.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      tx_show = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        tx_show = 1'b0;
        sent_count++;
      end
      if (!tx_show) begin
        if (tx_pause > 0) begin
          tx_pause--;
        end else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].drain &&
                       (expected_rsps.size() != 0 || (in_valid_i && in_ready_o)))) begin
          nxt_req = pending_reqs.pop_front();
          req_type_i <= nxt_req.op;
          position_i <= nxt_req.pos;
          value_i    <= nxt_req.val;
          tx_show    = 1'b1;
          tx_pause   = next_pause(tx_calm);
        end
      end
      in_valid_i <= tx_show;
    end
  end

  // Response monitor: predicts on each accepted request and checks each response beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_rsps.push_back(list_apply(req_e'(req_type_i), position_i, value_i));
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: response with nothing expected: status %0h, read_value %0h",
                   $time, status_o, read_value_o);
          mismatches++;
        end else begin
          want = expected_rsps.pop_front();
          check_field("status", want.status, status_o);
          check_field("read_value", want.rd, read_value_o);
          check_field("found_index", want.idx, found_index_o);
          check_field("list_count", want.cnt, list_count_o);
        end
        rx_hold = next_pause(rx_calm);
      end
      if (rx_hold > 0) begin
        out_ready_i <= 1'b0;
        rx_hold--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int n;
    int span;
    int r;
    int p;
    bit grow;
    req_e op;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    key_pool[4] = 32'h0000_0001;
    for (int k = 5; k < 16; k++) key_pool[k] = $urandom;

    // Directed: empty list, field extremes, duplicates, both ends and the middle.
    add_req(REQ_GET,    0,   32'h0,         1'b0);
    add_req(REQ_DELETE, 0,   32'h0,         1'b0);
    add_req(REQ_FIND,   0,   32'h0,         1'b0);
    add_req(REQ_INSERT, 1,   32'h1111_1111, 1'b0);
    add_req(REQ_INSERT, 0,   32'h8000_0000, 1'b0);
    add_req(REQ_INSERT, 1,   32'h7FFF_FFFF, 1'b0);
    add_req(REQ_INSERT, 0,   32'hFFFF_FFFF, 1'b0);
    add_req(REQ_INSERT, 3,   32'h0000_0000, 1'b0);
    add_req(REQ_INSERT, 2,   32'h7FFF_FFFF, 1'b0);
    add_req(REQ_INSERT, 5,   32'hAAAA_AAAA, 1'b0);
    add_req(REQ_FIND,   127, 32'h7FFF_FFFF, 1'b0);
    add_req(REQ_FIND,   0,   32'h8000_0000, 1'b0);
    add_req(REQ_FIND,   64,  32'h5555_5555, 1'b0);
    add_req(REQ_GET,    0,   32'hFFFF_FFFF, 1'b0);
    add_req(REQ_GET,    5,   32'h0,         1'b0);
    add_req(REQ_GET,    6,   32'h0,         1'b0);
    add_req(REQ_GET,    127, 32'h0,         1'b0);
    add_req(REQ_DELETE, 127, 32'h0,         1'b0);
    add_req(REQ_INSERT, 127, 32'h5555_5555, 1'b0);
    add_req(REQ_INSERT, 8,   32'h5555_5555, 1'b0);
    add_req(REQ_DELETE, 5,   32'h0,         1'b0);
    add_req(REQ_DELETE, 0,   32'h0,         1'b0);
    add_req(REQ_DELETE, 1,   32'h0,         1'b0);
    add_req(REQ_GET,    42,  32'hFFFF_FFFF, 1'b0);

    // Random: alternating grow and shrink phases so the list runs between empty and
    // full; each phase starts once the block has drained.
    n    = 0;
    grow = 1'b1;
    while (n < RANDOM_ITEMS) begin
      span = $urandom_range(150, 250);
      for (int i = 0; i < span && n < RANDOM_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (grow) op = (r < 75) ? REQ_INSERT : (r < 83) ? REQ_DELETE :
                       (r < 93) ? REQ_FIND : REQ_GET;
        else      op = (r < 8) ? REQ_INSERT : (r < 83) ? REQ_DELETE :
                       (r < 93) ? REQ_FIND : REQ_GET;
        r = $urandom_range(0, 99);
        if (r < 12 || op == REQ_FIND) p = $urandom_range(0, 127);
        else if (op == REQ_INSERT) p = (r < 20) ? gen_len : $urandom_range(0, gen_len);
        else if (gen_len == 0) p = 0;
        else p = (r < 20) ? gen_len - 1 : $urandom_range(0, gen_len - 1);
        if (op == REQ_INSERT) add_req(op, p, pick_value(40), i == 0);
        else if (op == REQ_FIND) add_req(op, p, pick_value(60), i == 0);
        else add_req(op, p, $urandom, i == 0);
        n++;
      end
      grow = !grow;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || in_valid_i || expected_rsps.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/plel_pkg.sv
sv/plel_cell.sv
sv/plel_gather.sv
sv/positional_list_engine_core.sv
dv/positional_list_engine_core_test.sv
